// ===== rtl/core/smpv_pkg.sv =====
// ----------------------------------------------------------------------------
// smpv_pkg
// Shared sizes, operation codes and beat types of the sample playback mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smpv_pkg;

  // Sizing
  localparam int Voices     = 8;
  localparam int MaxSamples = 16;
  localparam int StoreBytes = 4096;

  localparam int VIdxW = (Voices > 1) ? $clog2(Voices) : 1;
  localparam int VCntW = $clog2(Voices + 1);
  localparam int SIdxW = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int SCntW = $clog2(MaxSamples + 1);
  localparam int AddrW = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int LenW  = $clog2(StoreBytes + 1);

  // Command queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes
  localparam logic [1:0] CfgActiveVoices = 2'd0;
  localparam logic [1:0] CfgLoadGain     = 2'd1;
  localparam logic [1:0] CfgMuteOn       = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PLAY  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] sample_id;
    logic       loop_flag;
  } item_t;

  typedef struct packed {
    logic [3:0] active_voices;
    logic [7:0] load_gain;
    logic       mute_on;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/sample_playback_voice_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// sample_playback_voice_mixer_unit
// Multi-voice sample playback mixer: stores scaled 8-bit samples and mixes
// them on up to eight voices, one output byte per tick.
//
//   channel   direction  handshake                 payload
//   command   in         start high, busy low      op, data_byte, last_byte,
//                                                  sample_id, loop_flag
//   config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//   result    out        result_valid_o strobe     mixed_value_o
//
// Commands queue two beats deep; busy is high while that queue is full.
// Back end: a load centres its byte, passes it through the bit-serial gain
// divider (8 steps) when the gain is nonzero and the store has room, then
// appends it; a load into a full sample table is dropped.
// Tick: the voice walk visits each active voice through the single read port
// of the sample store, and each fetched byte passes the multiply-then-fold
// mix step; a muted tick returns zero without a walk.
// Results are a one-cycle strobe and cannot be held off. No clearing pass:
// the sample store and table hold nothing meaningful until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_playback_voice_mixer_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    op_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          last_byte_i,
  input  wire logic [3:0]    sample_id_i,
  input  wire logic          loop_flag_i,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  output logic               result_valid_o,
  output logic signed [7:0]  mixed_value_o
);

  smpv_pkg::cfg_t   cfg_q;
  smpv_pkg::item_t  head;
  logic             head_valid;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_voices <= 4'd8;
      cfg_q.load_gain     <= 8'd1;
      cfg_q.mute_on       <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        smpv_pkg::CfgActiveVoices: cfg_q.active_voices <= cfg_data_i[3:0];
        smpv_pkg::CfgLoadGain:     cfg_q.load_gain     <= cfg_data_i;
        smpv_pkg::CfgMuteOn:       cfg_q.mute_on       <= cfg_data_i[0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  smpv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .sample_id_i  (sample_id_i),
    .loop_flag_i  (loop_flag_i),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  smpv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .mixed_value_o  (mixed_value_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/smpv_ram.sv =====
// ----------------------------------------------------------------------------
// smpv_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smpv_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on enable, read every cycle into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/smpv_front.sv =====
// ----------------------------------------------------------------------------
// smpv_front
// Accepts command beats, classifies the operation and queues them for the
// back end. Busy is raised while the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smpv_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          op_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                last_byte_i,
  input  wire logic [3:0]          sample_id_i,
  input  wire logic                loop_flag_i,
  input  wire logic                pop_i,
  output smpv_pkg::item_t          head_o,
  output logic                     head_valid_o
);

  smpv_pkg::item_t                 slot_q [smpv_pkg::QDepth];
  logic [smpv_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [smpv_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [smpv_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            push;
  logic                            pop;
  smpv_pkg::item_t                 item;

  // Classify the incoming beat
  always_comb begin
    item.op        = smpv_pkg::op_e'(op_i);
    item.data_byte = data_byte_i;
    item.last_byte = last_byte_i;
    item.sample_id = sample_id_i;
    item.loop_flag = loop_flag_i;
  end

  assign busy         = (cnt_q == smpv_pkg::QCntW'(smpv_pkg::QDepth));
  assign push         = start && !busy;
  assign pop          = pop_i && (cnt_q != '0);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == smpv_pkg::QPtrW'(smpv_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == smpv_pkg::QPtrW'(smpv_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the accepted beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/smpv_back.sv =====
// ----------------------------------------------------------------------------
// smpv_back
// Executes queued commands: loads and scales sample bytes, starts voices,
// walks the voices on a tick and mixes them, and clears the playback state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smpv_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  smpv_pkg::cfg_t         cfg_i,
  input  smpv_pkg::item_t        head_i,
  input  wire logic              head_valid_i,
  output logic                   pop_o,
  output logic                   result_valid_o,
  output logic signed [7:0]      mixed_value_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_LOAD,
    S_VISIT,
    S_MUL,
    S_ACC
  } state_e;

  state_e                        state_q;
  smpv_pkg::item_t               cmd_q;

  // Loader state
  logic [smpv_pkg::SCntW-1:0]    stored_q;
  logic [smpv_pkg::LenW-1:0]     fill_q;
  logic [smpv_pkg::LenW-1:0]     cur_len_q;
  logic [smpv_pkg::AddrW-1:0]    cur_start_q;

  // Sample table
  logic [smpv_pkg::AddrW-1:0]    tbl_start_q [smpv_pkg::MaxSamples];
  logic [smpv_pkg::LenW-1:0]     tbl_len_q   [smpv_pkg::MaxSamples];

  // Voices
  logic [smpv_pkg::LenW-1:0]     vpos_q [smpv_pkg::Voices];
  logic [3:0]                    vsmp_q [smpv_pkg::Voices];
  logic                          vrep_q [smpv_pkg::Voices];

  // Mixer and divider datapath
  logic [smpv_pkg::VCntW-1:0]    vi_q;
  logic signed [7:0]             acc_q;
  logic signed [7:0]             s_q;
  logic signed [15:0]            p_q;
  logic [7:0]                    dvd_q;
  logic [7:0]                    rem_q;
  logic                          neg_q;
  logic [2:0]                    cnt_q;
  logic                          res_valid_q;
  logic signed [7:0]             res_value_q;

  logic [smpv_pkg::VCntW-1:0]    n_voices;
  logic [smpv_pkg::VIdxW-1:0]    vidx;
  logic [smpv_pkg::LenW-1:0]     cur_pos;
  logic [3:0]                    cur_sid;
  logic [smpv_pkg::SIdxW-1:0]    tbl_ridx;
  logic [smpv_pkg::LenW-1:0]     rd_len;
  logic [smpv_pkg::AddrW-1:0]    rd_start;
  logic [smpv_pkg::LenW:0]       vaddr;
  logic                          addr_ok;
  logic                          free_found;
  logic [smpv_pkg::VIdxW-1:0]    free_idx;
  logic                          play_ok;
  logic [7:0]                    c0;
  logic [7:0]                    c0_mag;
  logic [8:0]                    rem_sh;
  logic                          div_ge;
  logic [7:0]                    rem_nx;
  logic [7:0]                    ld_val;
  logic                          store_ok;
  logic                          tbl_we;
  logic [smpv_pkg::SIdxW-1:0]    tbl_widx;
  logic [smpv_pkg::AddrW-1:0]    tbl_wstart;
  logic [smpv_pkg::LenW-1:0]     tbl_wlen;
  logic [smpv_pkg::LenW-1:0]     len_nx;
  logic                          ram_we;
  logic [7:0]                    ram_rdata;
  logic signed [7:0]             s_rd;
  logic [15:0]                   p_mag;
  logic [16:0]                   q_sum;
  logic [7:0]                    q_mag;
  logic [7:0]                    q8;
  logic signed [7:0]             acc_nx;

  // Clamp the voice count
  always_comb begin
    if (int'(cfg_i.active_voices) > smpv_pkg::Voices) begin
      n_voices = smpv_pkg::VCntW'(smpv_pkg::Voices);
    end else begin
      n_voices = smpv_pkg::VCntW'(cfg_i.active_voices);
    end
  end

  // Current voice and its table entry (one read port, shared by play and tick)
  assign vidx     = vi_q[smpv_pkg::VIdxW-1:0];
  assign cur_pos  = vpos_q[vidx];
  assign cur_sid  = vsmp_q[vidx];
  assign tbl_ridx = (state_q == S_EXEC) ? smpv_pkg::SIdxW'(cmd_q.sample_id)
                                        : smpv_pkg::SIdxW'(cur_sid);
  assign rd_len   = tbl_len_q[tbl_ridx];
  assign rd_start = tbl_start_q[tbl_ridx];
  assign vaddr    = (smpv_pkg::LenW + 1)'(rd_start) + (smpv_pkg::LenW + 1)'(cur_pos)
                  - (smpv_pkg::LenW + 1)'(1);
  assign addr_ok  = (vaddr < (smpv_pkg::LenW + 1)'(smpv_pkg::StoreBytes));

  // Find the first idle, non-looping voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = smpv_pkg::Voices - 1; i >= 0; i--) begin
      if ((smpv_pkg::VCntW'(i) < n_voices) && (vpos_q[i] == '0) && !vrep_q[i]) begin
        free_found = 1'b1;
        free_idx   = smpv_pkg::VIdxW'(i);
      end
    end
  end

  assign play_ok = !cfg_i.mute_on && (int'(cmd_q.sample_id) < int'(stored_q))
                && (int'(cmd_q.sample_id) < smpv_pkg::MaxSamples) && (rd_len != '0);

  // Centre the raw byte and run one restoring division step
  assign c0     = cmd_q.data_byte - 8'd127;
  assign c0_mag = c0[7] ? (8'd0 - c0) : c0;
  assign rem_sh = {rem_q, dvd_q[7]};
  assign div_ge = (rem_sh >= {1'b0, cfg_i.load_gain});
  assign rem_nx = div_ge ? 8'(rem_sh - {1'b0, cfg_i.load_gain}) : rem_sh[7:0];
  assign ld_val = neg_q ? (8'd0 - dvd_q) : dvd_q;

  // Loader bookkeeping
  assign store_ok   = (fill_q < smpv_pkg::LenW'(smpv_pkg::StoreBytes));
  assign len_nx     = store_ok ? (cur_len_q + 1'b1) : cur_len_q;
  assign tbl_we     = (state_q == S_LOAD) && cmd_q.last_byte;
  assign tbl_widx   = stored_q[smpv_pkg::SIdxW-1:0];
  assign tbl_wstart = ((cur_len_q == '0) && store_ok) ? fill_q[smpv_pkg::AddrW-1:0]
                                                      : cur_start_q;
  assign tbl_wlen   = len_nx;
  assign ram_we     = (state_q == S_LOAD) && store_ok;

  // Mix step: acc + s - trunc(acc * s / 255)
  assign s_rd   = signed'(ram_rdata);
  assign p_mag  = p_q[15] ? (16'd0 - 16'(p_q)) : 16'(p_q);
  assign q_sum  = 17'(p_mag) + 17'(p_mag >> 8) + 17'd1;
  assign q_mag  = q_sum[15:8];
  assign q8     = p_q[15] ? (8'd0 - q_mag) : q_mag;
  assign acc_nx = signed'(8'(acc_q + s_q - signed'(q8)));

  assign pop_o = (state_q == S_IDLE) && head_valid_i;

  smpv_ram #(
    .Width (8),
    .Depth (smpv_pkg::StoreBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[smpv_pkg::AddrW-1:0]),
    .wdata_i (ld_val),
    .raddr_i (vaddr[smpv_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Close a sample into the table
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_start_q[tbl_widx] <= tbl_wstart;
      tbl_len_q[tbl_widx]   <= tbl_wlen;
    end
  end

  // Command sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stored_q    <= '0;
      fill_q      <= '0;
      cur_len_q   <= '0;
      vi_q        <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < smpv_pkg::Voices; i++) begin
        vpos_q[i] <= '0;
        vsmp_q[i] <= '0;
        vrep_q[i] <= 1'b0;
      end
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (head_valid_i) begin
            cmd_q   <= head_i;
            state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          unique case (cmd_q.op)
            smpv_pkg::OP_LOAD: begin
              if (int'(stored_q) >= smpv_pkg::MaxSamples) begin
                state_q <= S_IDLE;
              end else if (!store_ok || (cfg_i.load_gain == 8'd0)) begin
                dvd_q   <= c0;
                neg_q   <= 1'b0;
                state_q <= S_LOAD;
              end else begin
                dvd_q   <= c0_mag;
                neg_q   <= c0[7];
                rem_q   <= '0;
                cnt_q   <= '0;
                state_q <= S_DIV;
              end
            end
            smpv_pkg::OP_PLAY: begin
              if (play_ok && free_found) begin
                vpos_q[free_idx] <= smpv_pkg::LenW'(1);
                vsmp_q[free_idx] <= cmd_q.sample_id;
                vrep_q[free_idx] <= cmd_q.loop_flag;
              end
              state_q <= S_IDLE;
            end
            smpv_pkg::OP_TICK: begin
              if (cfg_i.mute_on) begin
                res_valid_q <= 1'b1;
                res_value_q <= '0;
                state_q     <= S_IDLE;
              end else begin
                acc_q   <= '0;
                vi_q    <= '0;
                state_q <= S_VISIT;
              end
            end
            smpv_pkg::OP_CLEAR: begin
              stored_q  <= '0;
              fill_q    <= '0;
              cur_len_q <= '0;
              for (int i = 0; i < smpv_pkg::Voices; i++) begin
                vpos_q[i] <= '0;
                vsmp_q[i] <= '0;
                vrep_q[i] <= 1'b0;
              end
              state_q <= S_IDLE;
            end
          endcase
        end

        // One quotient bit per cycle
        S_DIV: begin
          rem_q <= rem_nx;
          dvd_q <= {dvd_q[6:0], div_ge};
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            state_q <= S_LOAD;
          end
        end

        // Append the byte and close the sample on its last beat
        S_LOAD: begin
          if (store_ok) begin
            fill_q <= fill_q + 1'b1;
            if (cur_len_q == '0) begin
              cur_start_q <= fill_q[smpv_pkg::AddrW-1:0];
            end
          end
          if (cmd_q.last_byte) begin
            stored_q  <= stored_q + 1'b1;
            cur_len_q <= '0;
          end else begin
            cur_len_q <= len_nx;
          end
          state_q <= S_IDLE;
        end

        // Visit one voice: skip, wrap, stop or fetch its byte; past the last, emit the mix
        S_VISIT: begin
          if (vi_q >= n_voices) begin
            res_valid_q <= 1'b1;
            res_value_q <= acc_q;
            state_q     <= S_IDLE;
          end else if (cur_pos == '0) begin
            vi_q <= vi_q + 1'b1;
          end else if (cur_pos >= rd_len) begin
            vpos_q[vidx] <= vrep_q[vidx] ? smpv_pkg::LenW'(1) : '0;
            vi_q         <= vi_q + 1'b1;
          end else begin
            vpos_q[vidx] <= cur_pos + 1'b1;
            if (addr_ok) begin
              state_q <= S_MUL;
            end else begin
              vi_q <= vi_q + 1'b1;
            end
          end
        end

        S_MUL: begin
          p_q     <= acc_q * s_rd;
          s_q     <= s_rd;
          state_q <= S_ACC;
        end

        S_ACC: begin
          acc_q   <= acc_nx;
          vi_q    <= vi_q + 1'b1;
          state_q <= S_VISIT;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign mixed_value_o  = res_value_q;

endmodule

`default_nettype wire

// ===== rtl/core/smpv_checker.sv =====
// ----------------------------------------------------------------------------
// smpv_checker
// Port-level checks of the mixer: result strobes against accepted ticks and
// the queue back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smpv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  op_i,
  input wire logic        result_valid_o
);

  logic [2:0] pending_q;
  logic       tick_beat;

  assign tick_beat = start && !busy && (op_i == smpv_pkg::OP_TICK);

  // Track ticks accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (tick_beat && !result_valid_o) begin
      pending_q <= pending_q + 3'd1;
    end else if (result_valid_o && !tick_beat) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  // Every result answers an accepted tick
  a_result_has_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (pending_q != 3'd0))
    else $error("result strobe without an outstanding tick");

  // Queue plus back end hold at most three ticks
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more ticks outstanding than the queue can hold");

  // Results are isolated single-cycle strobes
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // Busy only rises after a beat was taken
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy raised without an accepted beat");

endmodule

bind sample_playback_voice_mixer_unit smpv_checker u_smpv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .op_i           (op_i),
  .result_valid_o (result_valid_o)
);

`default_nettype wire

// ===== tb/sample_playback_voice_mixer_unit_test.sv =====
// ----------------------------------------------------------------------------
// sample_playback_voice_mixer_unit_test
// Self-checking bench for the sample playback mixer. A bit-accurate mirror
// of the sample store, sample table, voices and registers is updated at
// every accepted command beat. Every tick pushes its predicted mixed byte,
// and each result strobe is checked against the oldest prediction. Directed
// tests cover the field extremes and edge cases. Randomised phases then
// load, play and tick under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_playback_voice_mixer_unit_test;

  // Cycles that let queued loads, plays and ticks finish after the last result
  localparam int SettleCycles = 80;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [1:0]        op_i        = smpv_pkg::OP_TICK;
  logic [7:0]        data_byte_i = 8'd0;
  logic              last_byte_i = 1'b0;
  logic [3:0]        sample_id_i = 4'd0;
  logic              loop_flag_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = smpv_pkg::CfgActiveVoices;
  logic [7:0]        cfg_data_i  = 8'd0;
  logic              result_valid_o;
  logic signed [7:0] mixed_value_o;

  // Mirror of the mixer state and registers
  logic [7:0]        mir_store [smpv_pkg::StoreBytes];
  int                mir_start [smpv_pkg::MaxSamples];
  int                mir_len   [smpv_pkg::MaxSamples];
  int                mir_count;
  int                mir_fill;
  int                voice_pos [smpv_pkg::Voices];
  int                voice_smp [smpv_pkg::Voices];
  bit                voice_rep [smpv_pkg::Voices];
  logic [3:0]        reg_voices = 4'd8;
  logic [7:0]        reg_gain   = 8'd1;
  bit                reg_mute   = 1'b0;

  logic signed [7:0] mix_expected [$];
  int                errors     = 0;
  bit                gaps_on    = 1'b1;
  int                loaded_ids = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sample_playback_voice_mixer_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .sample_id_i    (sample_id_i),
    .loop_flag_i    (loop_flag_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .mixed_value_o  (mixed_value_o)
  );

  // --------------------------------------------------------------------------
  // Mixer mirror
  // --------------------------------------------------------------------------

  // Keep the low byte as two's complement
  function automatic int to_s8(int v);
    logic signed [7:0] b;
    b = v[7:0];
    return int'(b);
  endfunction

  function automatic void clear_mixer();
    foreach (mir_store[a]) mir_store[a] = 8'd0;
    foreach (mir_start[s]) begin
      mir_start[s] = 0;
      mir_len[s]   = 0;
    end
    foreach (voice_pos[v]) begin
      voice_pos[v] = 0;
      voice_smp[v] = 0;
      voice_rep[v] = 1'b0;
    end
    mir_count = 0;
    mir_fill  = 0;
  endfunction

  function automatic int visited_voices();
    return (reg_voices > smpv_pkg::Voices) ? smpv_pkg::Voices : int'(reg_voices);
  endfunction

  // Centre, scale and append one byte; a closing beat ends the sample
  function automatic void append_byte(logic [7:0] raw, bit last);
    int cur;
    int c;
    cur = mir_count;
    if (cur >= smpv_pkg::MaxSamples) return;
    if (mir_fill < smpv_pkg::StoreBytes) begin
      c = to_s8(int'(raw) - 127);
      if (reg_gain != 8'd0) c = c / int'(reg_gain);
      if (mir_len[cur] == 0) mir_start[cur] = mir_fill;
      mir_store[mir_fill] = c[7:0];
      mir_fill++;
      mir_len[cur]++;
    end
    if (last) begin
      mir_count = cur + 1;
      if (cur + 1 < smpv_pkg::MaxSamples) mir_len[cur + 1] = 0;
    end
  endfunction

  // Claim the first idle, non-repeating voice
  function automatic void claim_voice(int id, bit repeat_on);
    int n;
    n = visited_voices();
    if (reg_mute || id >= mir_count || mir_len[id] == 0) return;
    for (int i = 0; i < n; i++) begin
      if (voice_pos[i] == 0 && !voice_rep[i]) begin
        voice_pos[i] = 1;
        voice_smp[i] = id;
        voice_rep[i] = repeat_on;
        return;
      end
    end
  endfunction

  // Advance the visited voices and fold their bytes into one mixed byte
  function automatic int mix_tick();
    int acc;
    int s;
    int n;
    int len;
    int addr;
    acc = 0;
    n   = visited_voices();
    if (reg_mute) return 0;
    for (int i = 0; i < n; i++) begin
      if (voice_pos[i] == 0) continue;
      len = mir_len[voice_smp[i] % smpv_pkg::MaxSamples];
      if (voice_pos[i] >= len) begin
        voice_pos[i] = voice_rep[i] ? 1 : 0;
        continue;
      end
      addr = mir_start[voice_smp[i] % smpv_pkg::MaxSamples] + voice_pos[i] - 1;
      voice_pos[i]++;
      if (addr >= smpv_pkg::StoreBytes) continue;
      s   = to_s8(int'(mir_store[addr]));
      acc = to_s8(acc + s - (acc * s) / 255);
    end
    return acc;
  endfunction

  initial clear_mixer();

  // Update the mirror on every accepted register write and command beat
  always @(posedge clk_i) begin : accept_beat
    int mixed;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          smpv_pkg::CfgActiveVoices: reg_voices = cfg_data_i[3:0];
          smpv_pkg::CfgLoadGain:     reg_gain   = cfg_data_i;
          smpv_pkg::CfgMuteOn:       reg_mute   = cfg_data_i[0];
          default:                   ;
        endcase
      end
      if (start && !busy) begin
        case (op_i)
          smpv_pkg::OP_LOAD: append_byte(data_byte_i, last_byte_i);
          smpv_pkg::OP_PLAY: claim_voice(int'(sample_id_i), loop_flag_i);
          smpv_pkg::OP_TICK: begin
            mixed = mix_tick();
            mix_expected.push_back(mixed[7:0]);
          end
          default: clear_mixer();
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic signed [7:0] got,
                                 logic signed [7:0] want);
    $display("%0t ns mixed_value_o %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_result
    logic signed [7:0] want;
    if (rst_ni && result_valid_o) begin
      if (mix_expected.size() == 0) begin
        report_mismatch("unexpected beat", mixed_value_o, 8'sbx);
      end else begin
        want = mix_expected.pop_front();
        if (mixed_value_o !== want) report_mismatch("wrong value", mixed_value_o, want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Hold one command beat until accepted; keep start high when no gap follows
  task automatic send_beat(smpv_pkg::op_e op, logic [7:0] raw, bit last, logic [3:0] id,
                           bit repeat_on);
    int gap;
    start       <= 1'b1;
    op_i        <= op;
    data_byte_i <= raw;
    last_byte_i <= last;
    sample_id_i <= id;
    loop_flag_i <= repeat_on;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_load(logic [7:0] raw, bit last);
    send_beat(smpv_pkg::OP_LOAD, raw, last, 4'($urandom_range(0, 15)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_play(logic [3:0] id, bit repeat_on);
    send_beat(smpv_pkg::OP_PLAY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              id, repeat_on);
  endtask

  task automatic send_ticks(int k);
    repeat (k) begin
      send_beat(smpv_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_clear();
    send_beat(smpv_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  // Load a whole sample of random bytes, closed by its final beat
  task automatic load_sample(int len);
    for (int i = 0; i < len; i++) send_load(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Drop start and wait for every predicted result
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (mix_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Write all registers once the block has gone quiet
  task automatic apply_config(logic [3:0] voices, logic [7:0] gain, bit mute);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(smpv_pkg::CfgActiveVoices, {4'd0, voices});
    write_reg(smpv_pkg::CfgLoadGain, gain);
    write_reg(smpv_pkg::CfgMuteOn, {7'd0, mute});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Byte extremes, looping and one-shot voices, bad ids, one-byte sample, clear
  task automatic test_basic();
    gaps_on = 1'b1;
    send_load(8'd0, 1'b0);
    send_load(8'd255, 1'b0);
    send_load(8'd127, 1'b0);
    send_load(8'd128, 1'b1);
    send_load(8'd200, 1'b1);
    send_play(4'd0, 1'b1);
    send_play(4'd1, 1'b0);
    send_play(4'd2, 1'b0);
    send_play(4'd15, 1'b1);
    send_ticks(6);
    send_clear();
    send_ticks(1);
    send_load(8'd100, 1'b1);
    send_play(4'd0, 1'b0);
    send_ticks(2);
  endtask

  // Gain extremes, voice counts out of range, no free voice and mute
  task automatic test_config_edges();
    apply_config(4'd8, 8'd0, 1'b0);
    send_clear();
    send_load(8'd0, 1'b0);
    send_load(8'd255, 1'b1);
    apply_config(4'd8, 8'd255, 1'b0);
    send_load(8'd0, 1'b0);
    send_load(8'd255, 1'b1);
    apply_config(4'd8, 8'd3, 1'b0);
    send_load(8'd10, 1'b0);
    send_load(8'd250, 1'b0);
    send_load(8'd60, 1'b1);
    apply_config(4'd0, 8'd3, 1'b0);
    send_play(4'd2, 1'b1);
    send_ticks(2);
    apply_config(4'd15, 8'd3, 1'b0);
    send_play(4'd2, 1'b1);
    send_play(4'd0, 1'b0);
    send_play(4'd1, 1'b1);
    send_ticks(3);
    apply_config(4'd1, 8'd3, 1'b0);
    send_play(4'd2, 1'b0);
    send_ticks(3);
    apply_config(4'd8, 8'd3, 1'b1);
    send_play(4'd0, 1'b0);
    send_ticks(2);
    send_load(8'd77, 1'b1);
    apply_config(4'd8, 8'd3, 1'b0);
    send_ticks(3);
    send_clear();
  endtask

  // Fill the sample table with one-byte samples, then load past it
  task automatic test_table_full();
    apply_config(4'd8, 8'd1, 1'b0);
    gaps_on = 1'b0;
    send_clear();
    repeat (smpv_pkg::MaxSamples) send_load(8'($urandom_range(0, 255)), 1'b1);
    send_load(8'($urandom_range(0, 255)), 1'b0);
    send_load(8'($urandom_range(0, 255)), 1'b1);
    send_play(4'd15, 1'b0);
    send_play(4'd0, 1'b1);
    send_ticks(3);
    gaps_on = 1'b1;
    send_clear();
  endtask

  // Mostly well-formed load, play and tick traffic, with some noise
  task automatic test_random_phase(logic [3:0] voices, logic [7:0] gain, bit mute,
                                   int beats);
    int done;
    int r;
    int len;
    int id;
    smpv_pkg::op_e op;
    bit last;
    apply_config(voices, gain, mute);
    loaded_ids = 0;
    send_clear();
    done = 1;
    while (done < beats) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (loaded_ids >= smpv_pkg::MaxSamples && $urandom_range(0, 1) == 1) begin
        send_clear();
        loaded_ids = 0;
        done++;
      end else if (r < 22) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        if (loaded_ids < smpv_pkg::MaxSamples) loaded_ids++;
        done += len;
        load_sample(len);
      end else if (r < 40) begin
        if (loaded_ids > 0 && $urandom_range(0, 4) != 0) id = $urandom_range(0, loaded_ids - 1);
        else id = $urandom_range(0, 15);
        done++;
        send_play(4'(id), 1'($urandom_range(0, 1)));
      end else if (r < 88) begin
        len = $urandom_range(1, 8);
        send_ticks(len);
        done += len;
        if ($urandom_range(0, 24) == 0) drain_results();
      end else if (r < 91) begin
        send_clear();
        loaded_ids = 0;
        done++;
      end else begin
        // Stray beat with random content, possibly breaking a sample in two
        op   = smpv_pkg::op_e'($urandom_range(0, 3));
        last = 1'($urandom_range(0, 1));
        if (op == smpv_pkg::OP_LOAD && last && loaded_ids < smpv_pkg::MaxSamples) begin
          loaded_ids++;
        end
        if (op == smpv_pkg::OP_CLEAR) loaded_ids = 0;
        done++;
        send_beat(op, 8'($urandom_range(0, 255)), last, 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic();
    test_config_edges();
    test_table_full();
    test_random_phase(4'd8, 8'd1,   1'b0, 100);
    test_random_phase(4'd3, 8'd2,   1'b0, 80);
    test_random_phase(4'd1, 8'd255, 1'b0, 50);
    test_random_phase(4'd8, 8'd5,   1'b0, 90);
    test_random_phase(4'd5, 8'd1,   1'b1, 45);
    test_random_phase(4'd8, 8'd128, 1'b0, 50);
    test_random_phase(4'd2, 8'd0,   1'b0, 60);

    // Wait out the remaining results, bounded, then let the block settle
    start <= 1'b0;
    for (int w = 0; w < 5000 && mix_expected.size() != 0; w++) @(posedge clk_i);
    if (mix_expected.size() != 0) begin
      report_mismatch("never arrived", 8'sbx, mix_expected[0]);
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("sample_playback_voice_mixer_unit_test: clean");
    end else begin
      $display("sample_playback_voice_mixer_unit_test: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("sample_playback_voice_mixer_unit_test: errors");
    $finish;
  end

endmodule
